// File: rtl/lgrs_pkg.sv
// Shared types, constants and functions for the life generation row stream.
// Used by the cell, the output queue, the top level and the checker.
// Depends on nothing.
package lgrs_pkg;

  localparam int ROW_W      = 64;
  localparam int MAX_WIDTH  = 64;
  localparam int MAX_ROWS   = 1024;
  localparam int ROW_CNT_W  = $clog2(MAX_ROWS + 1);
  localparam int OUT_ROW_W  = 10;
  localparam int CFG_W      = 7;
  localparam logic [CFG_W-1:0] RESET_WIDTH = CFG_W'(MAX_WIDTH);

  localparam logic [3:0] BIRTH_COUNT   = 4'd3;
  localparam logic [3:0] SURVIVE_COUNT = 4'd2;

  // Masked state of one column, as seen by the neighboring cells.
  typedef struct packed {
    logic upp;
    logic mid;
    logic row;
  } col_bits_t;

  typedef struct packed {
    logic [ROW_W-1:0]     next_bits;
    logic [OUT_ROW_W-1:0] out_row;
    logic                 grid_done;
  } result_t;

  // Up to two results enter the queue per cycle, packed from slot zero.
  typedef struct packed {
    logic    vld0;
    logic    vld1;
    result_t data0;
    result_t data1;
  } push_t;

  // B3/S23 rule on the eight neighbor bits and the cell itself.
  function automatic logic next_cell(input logic [7:0] nb, input logic here);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < 8; i++) begin
      n = n + 4'(nb[i]);
    end
    return (n == BIRTH_COUNT) || ((n == SURVIVE_COUNT) && here);
  endfunction

  // Row index of a result, saturating at the last row a grid can report.
  function automatic logic [OUT_ROW_W-1:0] row_index(input logic [ROW_CNT_W-1:0] idx);
    logic [ROW_CNT_W-1:0] sat;
    sat = (idx > ROW_CNT_W'(MAX_ROWS - 1)) ? ROW_CNT_W'(MAX_ROWS - 1) : idx;
    return OUT_ROW_W'(sat);
  endfunction

endpackage

// File: rtl/lgrs_cell.sv
// One column cell of the life stencil: holds two rows of its column.
// Depends on lgrs_pkg.
module lgrs_cell import lgrs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      live_i,
  input  logic      shift_i,
  input  logic      clear_i,
  input  logic      row_bit_i,
  input  col_bits_t left_i,
  input  col_bits_t right_i,
  output col_bits_t own_o,
  output logic      next_mid_o,
  output logic      next_row_o
);

  logic upp_r, upp_nxt;
  logic mid_r, mid_nxt;

  assign own_o.row = row_bit_i & live_i;
  assign own_o.mid = mid_r & live_i;
  assign own_o.upp = upp_r & live_i;

  // Next state of the held middle row, with the arriving row below it.
  assign next_mid_o = live_i & next_cell({left_i.upp, own_o.upp, right_i.upp,
                                          left_i.row, own_o.row, right_i.row,
                                          left_i.mid, right_i.mid}, own_o.mid);

  // Next state of the arriving row when it is the last one: dead below.
  assign next_row_o = live_i & next_cell({left_i.mid, own_o.mid, right_i.mid,
                                          left_i.row, right_i.row, 3'b000}, own_o.row);

  always_comb begin
    upp_nxt = upp_r;
    mid_nxt = mid_r;
    if (clear_i) begin
      upp_nxt = 1'b0;
      mid_nxt = 1'b0;
    end else if (shift_i) begin
      upp_nxt = mid_r;
      mid_nxt = own_o.row;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upp_r <= 1'b0;
      mid_r <= 1'b0;
    end else begin
      upp_r <= upp_nxt;
      mid_r <= mid_nxt;
    end
  end

endmodule

// File: rtl/lgrs_out_queue.sv
// Two-entry result queue that decouples the stencil from the output channel.
// Depends on lgrs_pkg.
module lgrs_out_queue import lgrs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  push_t      push_i,
  input  logic       out_stall_i,
  output logic       out_valid_o,
  output result_t    head_o,
  output logic [1:0] free_o
);

  result_t    slot0_r, slot0_nxt;
  result_t    slot1_r, slot1_nxt;
  logic [1:0] count_r, count_nxt;
  logic       pop;
  logic [1:0] kept;
  result_t    keep0;

  assign out_valid_o = (count_r != 2'd0);
  assign head_o      = slot0_r;
  assign pop         = out_valid_o && !out_stall_i;
  assign kept        = count_r - 2'(pop);
  assign keep0       = pop ? slot1_r : slot0_r;
  assign free_o      = 2'd2 - kept;

  always_comb begin
    slot0_nxt = slot0_r;
    slot1_nxt = slot1_r;
    case (kept)
      2'd0: begin
        slot0_nxt = push_i.data0;
        slot1_nxt = push_i.data1;
      end
      2'd1: begin
        slot0_nxt = keep0;
        slot1_nxt = push_i.data0;
      end
      default: begin
        slot0_nxt = slot0_r;
        slot1_nxt = slot1_r;
      end
    endcase
    count_nxt = kept + 2'(push_i.vld0) + 2'(push_i.vld1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 2'd0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot0_r <= slot0_nxt;
    slot1_r <= slot1_nxt;
  end

endmodule

// File: rtl/life_generation_row_stream.sv
// Top level of the streaming B3/S23 life generation step.
// Depends on lgrs_pkg, lgrs_cell and lgrs_out_queue.
//
// This block computes one generation of the B3/S23 cellular automaton on a
// bounded grid whose outside is dead. Grid rows enter top row first, one row
// per input transfer, with in_last_row set on the final row. A row of 64
// identical column cells holds the two previous rows; each cell works on its
// own column and trades its masked bits with its left and right neighbors in
// every cycle. Every row after the first yields the next state of the row
// above it, and the marked row also yields its own next state, so a grid of
// N rows gives N results, the last one flagged by out_grid_done. Columns at
// or above the configured width read as dead and come out as zero; out_row
// sticks at 1023 on very tall grids. The block takes one row per cycle while
// in_stall is low; results are registered in the two-entry result queue, which
// absorbs the double result of a marked row, so in_stall rises only when
// out_stall backs up that queue. The width register (reset value 64) is
// written with cfg_wr_en and should change only while the block is idle.
module life_generation_row_stream import lgrs_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [CFG_W-1:0]     cfg_row_width,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [ROW_W-1:0]     in_row_bits,
  input  logic                 in_last_row,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [ROW_W-1:0]     out_next_bits,
  output logic [OUT_ROW_W-1:0] out_row,
  output logic                 out_grid_done
);

  logic [CFG_W-1:0]     row_width_r;
  logic [ROW_CNT_W-1:0] rows_seen_r, rows_seen_nxt;

  logic             in_xfer;
  logic             have_above;
  logic [1:0]       need;
  logic [1:0]       free;
  logic             shift;
  logic             clear;

  col_bits_t        own_w   [ROW_W];
  col_bits_t        left_w  [ROW_W];
  col_bits_t        right_w [ROW_W];
  logic [ROW_W-1:0] live_w;
  logic [ROW_W-1:0] next_mid_w;
  logic [ROW_W-1:0] next_row_w;

  result_t          res_mid;
  result_t          res_last;
  push_t            push;
  result_t          head;

  // A row transfer needs one queue slot for the row above it (if any) and
  // one more when it closes the grid.
  assign have_above = (rows_seen_r != '0);
  assign need       = 2'(have_above) + 2'(in_last_row);
  assign in_stall   = (need > free);
  assign in_xfer    = in_valid && !in_stall;
  assign shift      = in_xfer && !in_last_row;
  assign clear      = in_xfer && in_last_row;

  // The column cells. Edge cells see dead columns outside the grid.
  for (genvar c = 0; c < ROW_W; c++) begin : g_col
    assign live_w[c] = (c < MAX_WIDTH) && (CFG_W'(c) < row_width_r);

    if (c == 0) begin : g_left_edge
      assign left_w[c] = '0;
    end else begin : g_left
      assign left_w[c] = own_w[c-1];
    end

    if (c == ROW_W - 1) begin : g_right_edge
      assign right_w[c] = '0;
    end else begin : g_right
      assign right_w[c] = own_w[c+1];
    end

    lgrs_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .live_i     (live_w[c]),
      .shift_i    (shift),
      .clear_i    (clear),
      .row_bit_i  (in_row_bits[c]),
      .left_i     (left_w[c]),
      .right_i    (right_w[c]),
      .own_o      (own_w[c]),
      .next_mid_o (next_mid_w[c]),
      .next_row_o (next_row_w[c])
    );
  end

  // The result for the held middle row, and for a marked row itself.
  assign res_mid.next_bits  = next_mid_w;
  assign res_mid.out_row    = row_index(rows_seen_r - ROW_CNT_W'(1));
  assign res_mid.grid_done  = 1'b0;
  assign res_last.next_bits = next_row_w;
  assign res_last.out_row   = row_index(rows_seen_r);
  assign res_last.grid_done = 1'b1;

  // Results are packed from the first slot so the queue keeps their order.
  assign push.vld0  = in_xfer && (have_above || in_last_row);
  assign push.vld1  = in_xfer && have_above && in_last_row;
  assign push.data0 = have_above ? res_mid : res_last;
  assign push.data1 = res_last;

  lgrs_out_queue u_queue (
    .clk         (clk),
    .rst_n       (rst_n),
    .push_i      (push),
    .out_stall_i (out_stall),
    .out_valid_o (out_valid),
    .head_o      (head),
    .free_o      (free)
  );

  assign out_next_bits = head.next_bits;
  assign out_row       = head.out_row;
  assign out_grid_done = head.grid_done;

  // Row counter: saturates on tall grids and returns to zero after the
  // marked row so the next grid starts clean.
  always_comb begin
    rows_seen_nxt = rows_seen_r;
    if (clear) begin
      rows_seen_nxt = '0;
    end else if (shift && (rows_seen_r < ROW_CNT_W'(MAX_ROWS))) begin
      rows_seen_nxt = rows_seen_r + ROW_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_width_r <= RESET_WIDTH;
      rows_seen_r <= '0;
    end else begin
      rows_seen_r <= rows_seen_nxt;
      if (cfg_wr_en) begin
        row_width_r <= cfg_row_width;
      end
    end
  end

endmodule

// File: rtl/lgrs_checker.sv
// Port-level checker for the life generation row stream, bound to the top.
// Depends on lgrs_pkg.
module lgrs_checker import lgrs_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic                 in_last_row,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic [ROW_W-1:0]     out_next_bits,
  input logic [OUT_ROW_W-1:0] out_row,
  input logic                 out_grid_done
);

  // A stalled result stays offered and unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_next_bits) &&
    $stable(out_row) && $stable(out_grid_done))
    else $error("stalled result changed or vanished");

  // Nothing is offered right after reset.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered after reset");

  // A transfer of the marked row always leaves a result to deliver.
  a_last_emits: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_last_row |=> out_valid)
    else $error("marked row produced no result");

endmodule

bind life_generation_row_stream lgrs_checker u_lgrs_checker (.*);
